FILE: src/srrw_pkg.sv
// package: shared types and constants of the selective-repeat receive window
`default_nettype none
package srrw_pkg;
    localparam int FRAME_W = 24;
    localparam int TIMER_W = 16;
    localparam int BYTES_W = 16;
    localparam int OSLOT_W = 5;

    typedef logic [1:0] t_code;

    localparam t_code OP_START  = 2'd0;
    localparam t_code OP_TICK   = 2'd1;
    localparam t_code OP_ARRIVE = 2'd2;

    localparam t_code KIND_REQ     = 2'd0;
    localparam t_code KIND_DLV     = 2'd1;
    localparam t_code KIND_DLV_REQ = 2'd2;

    localparam logic [1:0] REG_LAST_FRAME = 2'd0;
    localparam logic [1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_TAIL_BYTES = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NORM  = 9'b000000010,
        ST_START = 9'b000000100,
        ST_TRD   = 9'b000001000,
        ST_TUPD  = 9'b000010000,
        ST_TEND  = 9'b000100000,
        ST_TREQ  = 9'b001000000,
        ST_ARR   = 9'b010000000,
        ST_DLV   = 9'b100000000
    } t_state;
endpackage
`default_nettype wire

FILE: src/selective_repeat_receive_window.sv
// top level: selective-repeat receive window with slot sequencer
// An item is taken when start is high and busy is low; busy stays high until
// its last result has been shown. Results appear one per cycle on the result
// ports with o_valid high for one cycle and cannot be stalled. A start passes
// a setup state, then visits one slot per cycle and requests each slot in the
// window; a tick visits each slot in the window, reads the timer of each
// outstanding slot from the slot ram and writes it back, then requests a frame
// again when its timer has run out; after an arrival is checked, each frame that
// is ready is delivered in order; an unused opcode goes back to idle. After
// last_frame_index is lowered, the first item also reduces the base slot into
// the smaller window.
`default_nettype none
module selective_repeat_receive_window #(
    parameter int WINDOW_SLOTS = 32,
    parameter int FRAME_BYTES  = 1000
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [srrw_pkg::FRAME_W-1:0]  i_frame_number,
    output logic                               o_valid,
    output logic [1:0]                         o_kind,
    output logic [srrw_pkg::FRAME_W-1:0]       o_request_frame,
    output logic [srrw_pkg::FRAME_W-1:0]       o_deliver_frame,
    output logic [srrw_pkg::OSLOT_W-1:0]       o_deliver_slot,
    output logic [srrw_pkg::BYTES_W-1:0]       o_deliver_bytes,
    output logic                               o_complete,
    output logic                               o_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import srrw_pkg::*;

    localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int WW = $clog2(WINDOW_SLOTS + 1);
    localparam int AW = SW;
    localparam int RW = FRAME_W + TIMER_W;

    logic [FRAME_W-1:0] r_lfi;
    logic [TIMER_W-1:0] r_timeout;
    logic [BYTES_W-1:0] r_tail;

    t_state r_state, n_state;
    logic [1:0]         r_op;
    logic [FRAME_W-1:0] r_fr;
    logic [FRAME_W-1:0] r_base_frame;
    logic [SW-1:0]      r_base_slot;
    logic               r_rcv [WINDOW_SLOTS];
    logic [SW-1:0]      r_idx;
    logic [SW-1:0]      r_slot;
    logic [WW-1:0]      r_cnt;
    logic               r_found;
    logic [SW-1:0]      r_best;
    logic [TIMER_W-1:0] r_best_t;

    logic [WW-1:0]      w_size;
    logic [WW-1:0]      w_m1;
    logic               idx_end;
    logic [FRAME_W-1:0] diff;
    logic               in_win;
    logic [SW:0]        s_sum;
    logic [SW-1:0]      s_arr;
    logic [SW:0]        s_inc;
    logic [SW-1:0]      s_next;
    logic [FRAME_W:0]   refill_frame;
    logic               refill;
    logic               done;
    logic [BYTES_W-1:0] bytes;
    logic               dlv_last;
    logic [TIMER_W-1:0] t_rd;
    logic [FRAME_W-1:0] f_rd;
    logic [TIMER_W-1:0] t_dec;
    logic               cfg_wr;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_wa, ram_ra;
    logic [RW-1:0]  ram_wd, ram_rd;

    srrw_ram #(.WIDTH(RW), .DEPTH(WINDOW_SLOTS)) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        case (paddr[3:2])
            REG_LAST_FRAME: prdata = 32'(r_lfi);
            REG_TIMEOUT:    prdata = 32'(r_timeout);
            REG_TAIL_BYTES: prdata = 32'(r_tail);
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfi     <= '0;
            r_timeout <= TIMER_W'(10);
            r_tail    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LAST_FRAME: r_lfi     <= pwdata[FRAME_W-1:0];
                REG_TIMEOUT:    r_timeout <= pwdata[TIMER_W-1:0];
                REG_TAIL_BYTES: r_tail    <= pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_size  = (r_lfi < FRAME_W'(WINDOW_SLOTS)) ? WW'(r_lfi) + WW'(1) : WW'(WINDOW_SLOTS);
    assign w_m1    = w_size - WW'(1);
    assign idx_end = (WW'(r_idx) == w_m1);

    assign diff   = r_fr - r_base_frame;
    assign in_win = (r_fr >= r_base_frame) && (diff < FRAME_W'(w_size));
    assign s_sum  = (SW+1)'(r_base_slot) + (SW+1)'(diff);
    assign s_arr  = (s_sum >= (SW+1)'(w_size)) ? SW'(s_sum - (SW+1)'(w_size)) : SW'(s_sum);

    assign s_inc  = (SW+1)'(r_slot) + (SW+1)'(1);
    assign s_next = (s_inc == (SW+1)'(w_size)) ? '0 : SW'(s_inc);

    assign refill_frame = (FRAME_W+1)'(r_base_frame) + (FRAME_W+1)'(w_size);
    assign refill       = (refill_frame <= (FRAME_W+1)'(r_lfi));
    assign done         = (r_base_frame == r_lfi);
    assign bytes        = (done && r_tail != '0 && r_tail < BYTES_W'(FRAME_BYTES))
                          ? r_tail : BYTES_W'(FRAME_BYTES);
    assign dlv_last     = done || (r_cnt == w_m1) || !r_rcv[s_next];

    assign f_rd  = ram_rd[RW-1:TIMER_W];
    assign t_rd  = ram_rd[TIMER_W-1:0];
    assign t_dec = (t_rd != '0) ? t_rd - TIMER_W'(1) : t_rd;

    always_comb begin
        ram_we = 1'b0;
        ram_wa = AW'(r_idx);
        ram_wd = {FRAME_W'(r_idx), r_timeout};
        ram_re = 1'b0;
        ram_ra = AW'(r_idx);
        case (r_state)
            ST_START: ram_we = (WW'(r_idx) < w_size);
            ST_TRD:   ram_re = !r_rcv[r_idx];
            ST_TUPD: begin
                ram_we = 1'b1;
                ram_wd = {f_rd, t_dec};
            end
            ST_TEND: begin
                ram_re = 1'b1;
                ram_ra = AW'(r_best);
            end
            ST_TREQ: begin
                ram_we = 1'b1;
                ram_wa = AW'(r_best);
                ram_wd = {f_rd, r_timeout};
            end
            ST_DLV: begin
                ram_we = refill;
                ram_wa = AW'(r_slot);
                ram_wd = {refill_frame[FRAME_W-1:0], r_timeout};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (WW'(r_base_slot) < w_size) begin
                    case (r_op)
                        OP_START:  n_state = ST_START;
                        OP_TICK:   n_state = ST_TRD;
                        OP_ARRIVE: n_state = ST_ARR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                if (r_idx == SW'(WINDOW_SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_TRD: begin
                if (!r_rcv[r_idx]) n_state = ST_TUPD;
                else if (idx_end)  n_state = ST_TEND;
            end
            ST_TUPD: n_state = idx_end ? ST_TEND : ST_TRD;
            ST_TEND: n_state = (r_found && r_best_t == '0) ? ST_TREQ : ST_IDLE;
            ST_TREQ: n_state = ST_IDLE;
            ST_ARR: begin
                if (in_win && !r_rcv[s_arr] && r_fr == r_base_frame && r_base_frame <= r_lfi)
                    n_state = ST_DLV;
                else
                    n_state = ST_IDLE;
            end
            ST_DLV: begin
                if (dlv_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_base_frame <= '0;
            r_base_slot  <= '0;
            o_valid      <= 1'b0;
            for (int k = 0; k < WINDOW_SLOTS; k++) r_rcv[k] <= 1'b1;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_op  <= i_opcode;
                    r_fr  <= i_frame_number;
                    r_idx <= '0;
                end
                ST_NORM: begin
                    if (WW'(r_base_slot) >= w_size)
                        r_base_slot <= r_base_slot - SW'(w_size);
                    r_found <= 1'b0;
                    r_cnt   <= '0;
                end
                ST_START: begin
                    r_base_frame <= '0;
                    r_base_slot  <= '0;
                    r_idx        <= r_idx + SW'(1);
                    if (WW'(r_idx) < w_size) begin
                        r_rcv[r_idx]    <= 1'b0;
                        o_valid         <= 1'b1;
                        o_kind          <= KIND_REQ;
                        o_request_frame <= FRAME_W'(r_idx);
                        o_deliver_frame <= '0;
                        o_deliver_slot  <= '0;
                        o_deliver_bytes <= '0;
                        o_complete      <= 1'b0;
                        o_last          <= idx_end;
                    end else begin
                        r_rcv[r_idx] <= 1'b1;
                    end
                end
                ST_TRD: begin
                    if (r_rcv[r_idx] && !idx_end) r_idx <= r_idx + SW'(1);
                end
                ST_TUPD: begin
                    if (!r_found || t_dec < r_best_t) begin
                        r_found  <= 1'b1;
                        r_best   <= r_idx;
                        r_best_t <= t_dec;
                    end
                    if (!idx_end) r_idx <= r_idx + SW'(1);
                end
                ST_TREQ: begin
                    o_valid         <= 1'b1;
                    o_kind          <= KIND_REQ;
                    o_request_frame <= f_rd;
                    o_deliver_frame <= '0;
                    o_deliver_slot  <= '0;
                    o_deliver_bytes <= '0;
                    o_complete      <= 1'b0;
                    o_last          <= 1'b1;
                end
                ST_ARR: begin
                    r_slot <= s_arr;
                    if (in_win) r_rcv[s_arr] <= 1'b1;
                end
                ST_DLV: begin
                    o_valid         <= 1'b1;
                    o_kind          <= refill ? KIND_DLV_REQ : KIND_DLV;
                    o_request_frame <= refill ? refill_frame[FRAME_W-1:0] : '0;
                    o_deliver_frame <= r_base_frame;
                    o_deliver_slot  <= OSLOT_W'(r_slot);
                    o_deliver_bytes <= bytes;
                    o_complete      <= done;
                    o_last          <= dlv_last;
                    if (refill) r_rcv[r_slot] <= 1'b0;
                    r_base_frame <= r_base_frame + FRAME_W'(1);
                    r_base_slot  <= s_next;
                    r_slot       <= s_next;
                    r_cnt        <= r_cnt + WW'(1);
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/srrw_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: src/srrw_checker.sv
// checker: port-level properties of the receive window, bound to the top level
`default_nettype none
module srrw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_kind,
    input wire logic [23:0] o_request_frame,
    input wire logic [15:0] o_deliver_bytes,
    input wire logic        o_complete,
    input wire logic        o_last
);
    import srrw_pkg::*;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without an item in work");

    a_req_no_dlv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_REQ |-> o_deliver_bytes == '0 && !o_complete)
        else $error("request result carries delivery fields");

    a_dlv_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DLV |-> o_request_frame == '0)
        else $error("delivery-only result carries a request");

    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_complete |-> o_last) else $error("final frame not last transfer");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid) else $error("result after last transfer");
endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_kind          (o_kind),
    .o_request_frame (o_request_frame),
    .o_deliver_bytes (o_deliver_bytes),
    .o_complete      (o_complete),
    .o_last          (o_last)
);
`default_nettype wire

FILE: verif/selective_repeat_receive_window_tb.sv
// testbench: selective-repeat receive window checked against a behavioral predictor
`default_nettype none
module selective_repeat_receive_window_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srrw_pkg::*;

    localparam int WIN      = 32;
    localparam int FBYTES   = 1000;
    localparam int M24      = 24'hFFFFFF;
    localparam t_code OP_UNUSED = 2'd3;

    localparam int ROW_ITEM  = 0;
    localparam int ROW_TYPED = 1;
    localparam int ROW_CFG   = 2;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_opcode;
    logic [FRAME_W-1:0]  i_frame_number;
    logic                o_valid;
    logic [1:0]          o_kind;
    logic [FRAME_W-1:0]  o_request_frame;
    logic [FRAME_W-1:0]  o_deliver_frame;
    logic [OSLOT_W-1:0]  o_deliver_slot;
    logic [BYTES_W-1:0]  o_deliver_bytes;
    logic                o_complete;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    selective_repeat_receive_window u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_frame_number(i_frame_number),
        .o_valid(o_valid), .o_kind(o_kind), .o_request_frame(o_request_frame),
        .o_deliver_frame(o_deliver_frame), .o_deliver_slot(o_deliver_slot),
        .o_deliver_bytes(o_deliver_bytes), .o_complete(o_complete), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [1:0]         kind;
        logic [FRAME_W-1:0] req;
        logic [FRAME_W-1:0] dfr;
        logic [OSLOT_W-1:0] dslot;
        logic [BYTES_W-1:0] bytes;
        logic               done;
        logic               last;
    } window_res_t;

    typedef struct {
        int typ;
        int op;
        int val;
        int nres;
        int kind;
        int req;
        int dfr;
        int dslot;
        int bytes;
        int done;
    } row_t;

    window_res_t window_res_q[$];
    int          mismatches;
    int          items_sent;
    bit          no_gaps;

    // predictor state
    int unsigned last_frame_r;
    int unsigned timeout_r;
    int unsigned tail_r;
    int unsigned base_frame;
    int unsigned base_slot;
    bit          slot_rcvd [WIN];
    int unsigned slot_tmr [WIN];
    int unsigned slot_frm [WIN];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned window_slots();
        return (last_frame_r + 1 < WIN) ? last_frame_r + 1 : WIN;
    endfunction

    function automatic void push_res(int unsigned kind, int unsigned req, int unsigned dfr,
                                     int unsigned dslot, int unsigned bytes, bit done);
        window_res_t r;
        r.kind  = kind[1:0];
        r.req   = req[FRAME_W-1:0];
        r.dfr   = dfr[FRAME_W-1:0];
        r.dslot = dslot[OSLOT_W-1:0];
        r.bytes = bytes[BYTES_W-1:0];
        r.done  = done;
        r.last  = 1'b0;
        window_res_q.push_back(r);
    endfunction

    function automatic void predict_window(logic [1:0] op, logic [FRAME_W-1:0] fr_in, bit keep);
        int unsigned w, best, best_t, s, dl, nxt, bytes, fr;
        int          n_before;
        bit          found, done;
        w        = window_slots();
        n_before = window_res_q.size();
        fr       = fr_in;
        base_slot = base_slot % w;
        case (op)
            OP_START: begin
                base_frame = 0;
                base_slot  = 0;
                for (int i = 0; i < WIN; i++) begin
                    if (i < w) begin
                        slot_frm[i]  = i;
                        slot_tmr[i]  = timeout_r;
                        slot_rcvd[i] = 1'b0;
                        push_res(KIND_REQ, i, 0, 0, 0, 1'b0);
                    end else begin
                        slot_rcvd[i] = 1'b1;
                        slot_tmr[i]  = 0;
                    end
                end
            end
            OP_TICK: begin
                found = 1'b0;
                best = 0;
                best_t = 0;
                for (int i = 0; i < w; i++) begin
                    if (!slot_rcvd[i]) begin
                        if (slot_tmr[i] > 0) slot_tmr[i]--;
                        if (!found || slot_tmr[i] < best_t) begin
                            found  = 1'b1;
                            best   = i;
                            best_t = slot_tmr[i];
                        end
                    end
                end
                if (found && best_t == 0) begin
                    slot_tmr[best] = timeout_r;
                    push_res(KIND_REQ, slot_frm[best], 0, 0, 0, 1'b0);
                end
            end
            OP_ARRIVE: begin
                if (fr >= base_frame && fr < base_frame + w) begin
                    s = (base_slot + (fr - base_frame)) % w;
                    if (!slot_rcvd[s]) begin
                        slot_rcvd[s] = 1'b1;
                        dl = 0;
                        while (fr == base_frame - dl && dl < w && slot_rcvd[s] &&
                               base_frame <= last_frame_r) begin
                            done  = (base_frame == last_frame_r);
                            bytes = FBYTES;
                            nxt   = base_frame + w;
                            if (done && tail_r != 0 && tail_r < bytes) bytes = tail_r;
                            if (nxt <= last_frame_r) begin
                                slot_frm[s]  = nxt;
                                slot_tmr[s]  = timeout_r;
                                slot_rcvd[s] = 1'b0;
                                push_res(KIND_DLV_REQ, nxt, base_frame, s, bytes, done);
                            end else begin
                                push_res(KIND_DLV, 0, base_frame, s, bytes, done);
                            end
                            base_frame = (base_frame + 1) & M24;
                            s = (s + 1) % w;
                            base_slot = s;
                            dl++;
                            if (done) break;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (!keep) begin
            while (window_res_q.size() > n_before) void'(window_res_q.pop_back());
        end else if (window_res_q.size() > n_before) begin
            window_res_q[window_res_q.size()-1].last = 1'b1;
        end
    endfunction

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        window_res_t act, exp_r;
        if (i_rst_n && o_valid) begin
            act = '{o_kind, o_request_frame, o_deliver_frame, o_deliver_slot,
                    o_deliver_bytes, o_complete, o_last};
            if (window_res_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", act);
            end else begin
                exp_r = window_res_q.pop_front();
                if (act !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, act);
                end
            end
        end
    end

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return;
        if (r < 92) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        else repeat ($urandom_range(10, 40)) @(negedge i_clk);
    endtask

    task automatic send_item(logic [1:0] op, logic [FRAME_W-1:0] fr, int typed_n,
                             window_res_t typed_r);
        start          = 1'b1;
        i_opcode       = op;
        i_frame_number = fr;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_window(op, fr, typed_n < 0);
        if (typed_n == 1) window_res_q.push_back(typed_r);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
        idle_gap();
    endtask

    task automatic wait_drained();
        while (window_res_q.size() != 0 || busy) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_drained();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (idx)
            REG_LAST_FRAME: last_frame_r = data & M24;
            REG_TIMEOUT:    timeout_r = data & 32'hFFFF;
            default:        tail_r = data & 32'hFFFF;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    row_t dir_tab [24] = '{
        '{ROW_TYPED, OP_TICK,    0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_TYPED, OP_ARRIVE,  0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_TYPED, OP_ARRIVE,  M24,     0, 0, 0, 0, 0, 0,    0},
        '{ROW_TYPED, OP_UNUSED,  0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_TYPED, OP_START,   0,       1, KIND_REQ, 0, 0, 0, 0, 0},
        '{ROW_TYPED, OP_ARRIVE,  1,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_TYPED, OP_ARRIVE,  0,       1, KIND_DLV, 0, 0, 0, FBYTES, 1},
        '{ROW_TYPED, OP_ARRIVE,  0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_CFG,   REG_LAST_FRAME, 40,  0, 0, 0, 0, 0, 0,    0},
        '{ROW_CFG,   REG_TIMEOUT,    1,   0, 0, 0, 0, 0, 0,    0},
        '{ROW_CFG,   REG_TAIL_BYTES, 65535, 0, 0, 0, 0, 0, 0,  0},
        '{ROW_ITEM,  OP_START,   0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_TICK,    0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_ARRIVE,  2,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_ARRIVE,  1,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_ARRIVE,  0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_ARRIVE,  31,      0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_ARRIVE,  M24,     0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_UNUSED,  M24,     0, 0, 0, 0, 0, 0,    0},
        '{ROW_CFG,   REG_TIMEOUT,    0,   0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_TICK,    0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_ITEM,  OP_TICK,    0,       0, 0, 0, 0, 0, 0,    0},
        '{ROW_CFG,   REG_TIMEOUT,    65535, 0, 0, 0, 0, 0, 0,  0},
        '{ROW_ITEM,  OP_ARRIVE,  3,       0, 0, 0, 0, 0, 0,    0}
    };

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        window_res_t typed_r;
        int unsigned w, pick, lf, phase_len;
        logic [1:0]  op;
        logic [FRAME_W-1:0] fr;
        start = 1'b0;
        i_opcode = OP_TICK;
        i_frame_number = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        last_frame_r = 0;
        timeout_r = 10;
        tail_r = 0;
        base_frame = 0;
        base_slot = 0;
        for (int i = 0; i < WIN; i++) begin
            slot_rcvd[i] = 1'b1;
            slot_tmr[i] = 0;
            slot_frm[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].typ == ROW_CFG) begin
                write_reg(2'(dir_tab[k].op), 32'(dir_tab[k].val));
            end else begin
                typed_r = '{2'(dir_tab[k].kind), FRAME_W'(dir_tab[k].req),
                            FRAME_W'(dir_tab[k].dfr), OSLOT_W'(dir_tab[k].dslot),
                            BYTES_W'(dir_tab[k].bytes), 1'(dir_tab[k].done), 1'b1};
                send_item(2'(dir_tab[k].op), FRAME_W'(dir_tab[k].val),
                          (dir_tab[k].typ == ROW_TYPED) ? dir_tab[k].nres : -1, typed_r);
            end
        end

        while (items_sent < 280) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       lf = 0;
                1:       lf = M24;
                2:       lf = $urandom_range(1, 5);
                3:       lf = $urandom_range(30, 34);
                default: lf = $urandom_range(35, 90);
            endcase
            write_reg(REG_LAST_FRAME, lf | ($urandom() & 32'hFF00_0000));
            pick = $urandom_range(0, 7);
            write_reg(REG_TIMEOUT, (pick == 0) ? 0 : (pick == 1) ? 65535 :
                      (pick == 2) ? (32'hFFFF_0000 | $urandom_range(1, 6)) :
                      $urandom_range(1, 6));
            pick = $urandom_range(0, 5);
            write_reg(REG_TAIL_BYTES, (pick == 0) ? 0 : (pick == 1) ? 65535 :
                      (pick == 2) ? FBYTES : $urandom_range(1, 65535));
            no_gaps = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(15, 60);
            if ($urandom_range(0, 3) != 0) begin
                typed_r = '0;
                send_item(OP_START, FRAME_W'($urandom()), -1, typed_r);
            end
            repeat (phase_len) begin
                w = window_slots();
                pick = $urandom_range(0, 99);
                fr = FRAME_W'($urandom());
                if (pick < 70) begin
                    op = OP_ARRIVE;
                    fr = FRAME_W'((base_frame + $urandom_range(0, w - 1)) & M24);
                end else if (pick < 88) begin
                    op = OP_TICK;
                end else if (pick < 92) begin
                    op = OP_ARRIVE;
                    fr = FRAME_W'((base_frame + w + $urandom_range(0, 3)) & M24);
                end else if (pick < 95) begin
                    op = OP_ARRIVE;
                end else if (pick < 97) begin
                    op = OP_UNUSED;
                end else begin
                    op = OP_START;
                end
                if ($urandom_range(0, 19) == 0) wait_drained();
                send_item(op, fr, -1, typed_r);
            end
        end

        while (window_res_q.size() != 0 || busy) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (mismatches == 0 && window_res_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
